/* sv/pressure_temp_compensation_defines.svh */
// ----------------------------------------------------------------------------
// Pressure/temperature compensation - assertion macros
// Shared concurrent assertion forms used by the RTL of the block.
// ----------------------------------------------------------------------------
`ifndef PRESSURE_TEMP_COMPENSATION_DEFINES_SVH
`define PRESSURE_TEMP_COMPENSATION_DEFINES_SVH

// same-cycle implication
`define PTC_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PTC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/ptc_pkg.sv */
// ----------------------------------------------------------------------------
// ptc_pkg
// Types and constants of the pressure/temperature compensation block.
// ----------------------------------------------------------------------------
package ptc_pkg;

    localparam int CFG_ADDR_W  = 3;
    localparam int CFG_DATA_W  = 32;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 40;
    localparam int DIV_W       = 33;

    localparam int C_T_RND    = 8;
    localparam int C_B6_OFS   = 4000;
    localparam int C_B7_SCALE = 50000;
    localparam int C_U_OFS    = 32768;
    localparam int C_P_K1     = 3038;
    localparam int C_P_K2     = 7357;
    localparam int C_P_K3     = 3791;
    localparam int T_MAX      = 32767;
    localparam int T_MIN      = -32768;
    localparam int PRES_MAX   = 262143;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_AC1_AC2 = 3'd0,
        CFG_AC3_AC4 = 3'd1,
        CFG_AC5_AC6 = 3'd2,
        CFG_B1_B2   = 3'd3,
        CFG_MC_MD   = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic             valid;
        logic [DIV_W-1:0] dividend;
        logic [DIV_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             valid;
        logic [DIV_W-1:0] quotient;
    } t_div_rsp;

    // carried alongside the temperature divider
    typedef struct packed {
        logic signed [18:0] x1;
        logic [18:0]        up;
        logic [1:0]         oss;
        logic               neg;
        logic               dz;
    } t_tside;

    // carried alongside the pressure divider
    typedef struct packed {
        logic signed [15:0] temp;
        logic               big;
        logic               bz;
    } t_pside;

endpackage

/* sv/pressure_temp_compensation.sv */
// ----------------------------------------------------------------------------
// pressure_temp_compensation
// Integer compensation of raw barometric temperature and pressure words.
// ----------------------------------------------------------------------------
// Usage:
//   Calibration words are written on the cfg port (index 0..4: ac1/ac2,
//   ac3/ac4, ac5/ac6, b1/b2, mc/md) while the pipeline holds no words.
//   Each input word carries raw temperature, raw pressure and oversampling.
//   Each output word carries temperature in 0.1 C and pressure in Pa; tuser
//   flags a zero pressure divisor, with the pressure field forced to zero.
// Throughput: one word per cycle, sustained while the output word is not held.
// Pipeline: two 33-stage restoring dividers (temperature, then pressure),
//   with 16 arithmetic stages around them.
// Reset: clears all valid bits and the calibration words to zero.
// Stall: the whole pipeline holds while the output word waits; tready on
//   the input side drops only then, and nothing is lost or repeated.
// ----------------------------------------------------------------------------
`include "pressure_temp_compensation_defines.svh"

module pressure_temp_compensation
    import ptc_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CFG_ADDR_W-1:0]  i_cfg_addr,
    input  logic [CFG_DATA_W-1:0]  i_cfg_wdata,
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  i_s_axis_tdata,  // raw_temperature, raw_pressure, oversampling
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    output logic [OUT_TDATA_W-1:0] o_m_axis_tdata,  // temperature_tenths, pressure_pascal
    output logic                   o_m_axis_tuser   // divide_fault
);

    // calibration
    logic [CFG_DATA_W-1:0] r_cfg_ac1_ac2, r_cfg_ac3_ac4, r_cfg_ac5_ac6;
    logic [CFG_DATA_W-1:0] r_cfg_b1_b2, r_cfg_mc_md;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_ac1_ac2 <= '0;
            r_cfg_ac3_ac4 <= '0;
            r_cfg_ac5_ac6 <= '0;
            r_cfg_b1_b2   <= '0;
            r_cfg_mc_md   <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_addr))
                CFG_AC1_AC2: r_cfg_ac1_ac2 <= i_cfg_wdata;
                CFG_AC3_AC4: r_cfg_ac3_ac4 <= i_cfg_wdata;
                CFG_AC5_AC6: r_cfg_ac5_ac6 <= i_cfg_wdata;
                CFG_B1_B2:   r_cfg_b1_b2   <= i_cfg_wdata;
                CFG_MC_MD:   r_cfg_mc_md   <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    logic signed [15:0] w_ac1, w_ac2, w_ac3, w_b1, w_b2, w_mc, w_md;
    logic [15:0]        w_ac4, w_ac5, w_ac6;

    assign w_ac1 = $signed(r_cfg_ac1_ac2[31:16]);
    assign w_ac2 = $signed(r_cfg_ac1_ac2[15:0]);
    assign w_ac3 = $signed(r_cfg_ac3_ac4[31:16]);
    assign w_ac4 = r_cfg_ac3_ac4[15:0];
    assign w_ac5 = r_cfg_ac5_ac6[31:16];
    assign w_ac6 = r_cfg_ac5_ac6[15:0];
    assign w_b1  = $signed(r_cfg_b1_b2[31:16]);
    assign w_b2  = $signed(r_cfg_b1_b2[15:0]);
    assign w_mc  = $signed(r_cfg_mc_md[31:16]);
    assign w_md  = $signed(r_cfg_mc_md[15:0]);

    logic w_en;
    assign w_en            = !o_m_axis_tvalid || i_m_axis_tready;
    assign o_s_axis_tready = w_en;

    // stage registers
    logic               r_s1_vld, r_s2_vld, r_s3_vld, r_s4_vld, r_s5_vld, r_s6_vld;
    logic               r_s7_vld, r_s8_vld, r_s9_vld, r_s10_vld, r_s11_vld, r_s12_vld;
    logic               r_s13_vld, r_s14_vld, r_s15_vld, r_out_vld;

    logic signed [16:0] r_s1_d;
    logic [18:0]        r_s1_up, r_s2_up, r_s3_up;
    logic [1:0]         r_s1_oss, r_s2_oss, r_s3_oss;
    logic signed [33:0] r_s2_prod;
    logic signed [18:0] r_s3_x1;
    logic signed [19:0] r_s3_den;
    t_tside             r_tside [DIV_W];

    logic signed [18:0] r_s4_x1;
    logic signed [27:0] r_s4_x2, r_s5_b5, r_s6_b6;
    logic [18:0]        r_s4_up, r_s5_up, r_s6_up, r_s7_up, r_s8_up, r_s9_up;
    logic [18:0]        r_s10_up, r_s11_up;
    logic [1:0]         r_s4_oss, r_s5_oss, r_s6_oss, r_s7_oss, r_s8_oss, r_s9_oss;
    logic [1:0]         r_s10_oss, r_s11_oss, r_s12_oss;
    logic signed [15:0] r_s6_t, r_s7_t, r_s8_t, r_s9_t, r_s10_t, r_s11_t, r_s12_t;
    logic signed [15:0] r_s13_t, r_s14_t, r_s15_t, r_out_t;
    logic [52:0]        r_s7_sqf;
    logic signed [43:0] r_s7_ac2b6, r_s7_ac3b6;
    logic signed [37:0] r_s8_b2lo, r_s8_b2hi, r_s8_b1lo, r_s8_b1hi;
    logic signed [32:0] r_s8_x2a, r_s9_x2a;
    logic signed [30:0] r_s8_x1b, r_s9_x1b;
    logic signed [58:0] r_s9_b2sq, r_s9_b1sq;
    logic signed [49:0] r_s10_x3a;
    logic [31:0]        r_s10_x3b, r_s11_b3, r_s11_u, r_s12_diff, r_s13_b7;
    logic [32:0]        r_s12_b4, r_s13_b4;
    t_pside             r_pside [DIV_W];

    logic [18:0]        r_s14_p, r_s15_p;
    logic               r_s14_sat, r_s15_sat, r_s14_bz, r_s15_bz;
    logic [21:0]        r_s14_s;
    logic [31:0]        r_s14_m;
    logic [17:0]        r_s15_x1;
    logic signed [16:0] r_s15_x2;
    logic [17:0]        r_out_p;
    logic               r_out_fault;

    // stage 1
    logic signed [16:0] n_d;
    assign n_d = $signed({1'b0, i_s_axis_tdata[15:0]}) - $signed({1'b0, w_ac6});

    // stage 2
    logic signed [33:0] n_prod;
    assign n_prod = r_s1_d * $signed({1'b0, w_ac5});

    // stage 3
    logic signed [18:0] n_x1;
    logic signed [19:0] n_den;
    assign n_x1  = $signed(r_s2_prod[33:15]);
    assign n_den = n_x1 + w_md;

    // temperature divider
    logic signed [16:0] w_mc_x;
    logic [16:0]        w_mc_abs;
    logic [19:0]        w_den_abs;
    t_div_req           w_tdiv_req;
    t_div_rsp           w_tdiv_rsp;
    t_tside             w_tside_in;
    t_tside             w_tside_out;

    assign w_mc_x    = w_mc;
    assign w_mc_abs  = w_mc_x[16] ? 17'(-w_mc_x) : 17'(w_mc_x);
    assign w_den_abs = r_s3_den[19] ? 20'(-r_s3_den) : 20'(r_s3_den);

    always_comb begin
        w_tdiv_req.valid    = r_s3_vld;
        w_tdiv_req.dividend = {5'b0, w_mc_abs, 11'b0};
        w_tdiv_req.divisor  = {13'b0, w_den_abs};
        w_tside_in.x1       = r_s3_x1;
        w_tside_in.up       = r_s3_up;
        w_tside_in.oss      = r_s3_oss;
        w_tside_in.neg      = w_mc[15] ^ r_s3_den[19];
        w_tside_in.dz       = (r_s3_den == '0);
    end

    ptc_div u_tdiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_req   (w_tdiv_req),
        .o_rsp   (w_tdiv_rsp)
    );

    assign w_tside_out = r_tside[DIV_W-1];

    // stage 4: signed quotient
    logic signed [27:0] w_q28;
    logic signed [27:0] n_x2;
    assign w_q28 = $signed({1'b0, w_tdiv_rsp.quotient[26:0]});
    assign n_x2  = w_tside_out.dz ? 28'sd0 : (w_tside_out.neg ? -w_q28 : w_q28);

    // stage 5
    logic signed [27:0] n_b5;
    assign n_b5 = r_s4_x1 + r_s4_x2;

    // stage 6: temperature and b6
    logic signed [27:0] w_b5r;
    logic signed [23:0] w_t24;
    logic signed [15:0] n_t;
    logic signed [27:0] n_b6;
    assign w_b5r = r_s5_b5 + 28'(C_T_RND);
    assign w_t24 = $signed(w_b5r[27:4]);
    assign n_t   = (w_t24 > 24'(T_MAX)) ? 16'(T_MAX) :
                   (w_t24 < 24'(T_MIN)) ? 16'(T_MIN) : w_t24[15:0];
    assign n_b6  = r_s5_b5 - 28'(C_B6_OFS);

    // stage 7
    logic signed [55:0] n_sqf;
    logic signed [43:0] n_ac2b6, n_ac3b6;
    assign n_sqf   = r_s6_b6 * r_s6_b6;
    assign n_ac2b6 = w_ac2 * r_s6_b6;
    assign n_ac3b6 = w_ac3 * r_s6_b6;

    // stage 8: partial products on sq
    logic [40:0]        w_sq;
    logic signed [37:0] n_b2lo, n_b2hi, n_b1lo, n_b1hi;
    assign w_sq   = r_s7_sqf[52:12];
    assign n_b2lo = w_b2 * $signed({1'b0, w_sq[20:0]});
    assign n_b2hi = w_b2 * $signed({1'b0, w_sq[40:21]});
    assign n_b1lo = w_b1 * $signed({1'b0, w_sq[20:0]});
    assign n_b1hi = w_b1 * $signed({1'b0, w_sq[40:21]});

    // stage 9
    logic signed [58:0] n_b2sq, n_b1sq;
    assign n_b2sq = (r_s8_b2hi <<< 21) + r_s8_b2lo;
    assign n_b1sq = (r_s8_b1hi <<< 21) + r_s8_b1lo;

    // stage 10
    logic signed [49:0] n_x3a;
    logic signed [44:0] w_x3b_sum;
    assign n_x3a     = $signed(r_s9_b2sq[58:11]) + r_s9_x2a;
    assign w_x3b_sum = $signed(r_s9_b1sq[58:16]) + r_s9_x1b + 45'sd2;

    // stage 11: b3 (low 32 bits) and u
    logic [33:0] w_b3_base, w_b3_sh;
    logic [31:0] n_u;
    assign w_b3_base = 34'(r_s10_x3a) + 34'($signed({w_ac1, 2'b00}));
    assign w_b3_sh   = (w_b3_base << r_s10_oss) + 34'd2;
    assign n_u       = r_s10_x3b + 32'(C_U_OFS);

    // stage 12
    logic [47:0] n_b4p;
    logic [31:0] n_diff;
    assign n_b4p  = w_ac4 * r_s11_u;
    assign n_diff = {13'b0, r_s11_up} - r_s11_b3;

    // stage 13
    logic [15:0] w_scale;
    logic [31:0] n_b7;
    assign w_scale = 16'(C_B7_SCALE >> r_s12_oss);
    assign n_b7    = r_s12_diff * {16'b0, w_scale};

    // pressure divider
    t_div_req w_pdiv_req;
    t_div_rsp w_pdiv_rsp;
    t_pside   w_pside_in;
    t_pside   w_pside_out;

    always_comb begin
        w_pdiv_req.valid    = r_s13_vld;
        w_pdiv_req.dividend = r_s13_b7[31] ? {1'b0, r_s13_b7} : {r_s13_b7, 1'b0};
        w_pdiv_req.divisor  = r_s13_b4;
        w_pside_in.temp     = r_s13_t;
        w_pside_in.big      = r_s13_b7[31];
        w_pside_in.bz       = (r_s13_b4 == '0);
    end

    ptc_div u_pdiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_req   (w_pdiv_req),
        .o_rsp   (w_pdiv_rsp)
    );

    assign w_pside_out = r_pside[DIV_W-1];

    // stage 14
    logic [33:0] w_pq;
    logic [18:0] n_p;
    logic [21:0] n_s;
    logic [31:0] n_m;
    assign w_pq = w_pside_out.big ? {w_pdiv_rsp.quotient, 1'b0}
                                  : {1'b0, w_pdiv_rsp.quotient};
    assign n_p  = w_pq[18:0];
    assign n_s  = n_p[18:8] * n_p[18:8];
    assign n_m  = n_p * 13'(C_P_K2);

    // stage 15
    logic [33:0]        w_k1p;
    logic signed [32:0] w_negm;
    assign w_k1p  = r_s14_s * 12'(C_P_K1);
    assign w_negm = -$signed({1'b0, r_s14_m});

    // output stage
    logic signed [19:0] w_csum;
    logic signed [20:0] w_pres;
    logic [17:0]        n_out_p;
    assign w_csum = $signed({2'b00, r_s15_x1}) + r_s15_x2 + 20'(C_P_K3);
    assign w_pres = $signed({2'b00, r_s15_p}) + $signed(w_csum[19:4]);

    always_comb begin
        if (r_s15_bz) begin
            n_out_p = '0;
        end else if (r_s15_sat || (w_pres > 21'(PRES_MAX))) begin
            n_out_p = 18'(PRES_MAX);
        end else if (w_pres < 21'sd0) begin
            n_out_p = '0;
        end else begin
            n_out_p = w_pres[17:0];
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_s2_vld  <= 1'b0;
            r_s3_vld  <= 1'b0;
            r_s4_vld  <= 1'b0;
            r_s5_vld  <= 1'b0;
            r_s6_vld  <= 1'b0;
            r_s7_vld  <= 1'b0;
            r_s8_vld  <= 1'b0;
            r_s9_vld  <= 1'b0;
            r_s10_vld <= 1'b0;
            r_s11_vld <= 1'b0;
            r_s12_vld <= 1'b0;
            r_s13_vld <= 1'b0;
            r_s14_vld <= 1'b0;
            r_s15_vld <= 1'b0;
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_s1_vld  <= i_s_axis_tvalid;
            r_s2_vld  <= r_s1_vld;
            r_s3_vld  <= r_s2_vld;
            r_s4_vld  <= w_tdiv_rsp.valid;
            r_s5_vld  <= r_s4_vld;
            r_s6_vld  <= r_s5_vld;
            r_s7_vld  <= r_s6_vld;
            r_s8_vld  <= r_s7_vld;
            r_s9_vld  <= r_s8_vld;
            r_s10_vld <= r_s9_vld;
            r_s11_vld <= r_s10_vld;
            r_s12_vld <= r_s11_vld;
            r_s13_vld <= r_s12_vld;
            r_s14_vld <= w_pdiv_rsp.valid;
            r_s15_vld <= r_s14_vld;
            r_out_vld <= r_s15_vld;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1_d     <= n_d;
            r_s1_up    <= i_s_axis_tdata[34:16];
            r_s1_oss   <= i_s_axis_tdata[36:35];

            r_s2_prod  <= n_prod;
            r_s2_up    <= r_s1_up;
            r_s2_oss   <= r_s1_oss;

            r_s3_x1    <= n_x1;
            r_s3_den   <= n_den;
            r_s3_up    <= r_s2_up;
            r_s3_oss   <= r_s2_oss;

            r_tside[0] <= w_tside_in;
            for (int k = 1; k < DIV_W; k++) begin
                r_tside[k] <= r_tside[k-1];
            end

            r_s4_x1    <= w_tside_out.x1;
            r_s4_x2    <= n_x2;
            r_s4_up    <= w_tside_out.up;
            r_s4_oss   <= w_tside_out.oss;

            r_s5_b5    <= n_b5;
            r_s5_up    <= r_s4_up;
            r_s5_oss   <= r_s4_oss;

            r_s6_b6    <= n_b6;
            r_s6_t     <= n_t;
            r_s6_up    <= r_s5_up;
            r_s6_oss   <= r_s5_oss;

            r_s7_sqf   <= n_sqf[52:0];
            r_s7_ac2b6 <= n_ac2b6;
            r_s7_ac3b6 <= n_ac3b6;
            r_s7_t     <= r_s6_t;
            r_s7_up    <= r_s6_up;
            r_s7_oss   <= r_s6_oss;

            r_s8_b2lo  <= n_b2lo;
            r_s8_b2hi  <= n_b2hi;
            r_s8_b1lo  <= n_b1lo;
            r_s8_b1hi  <= n_b1hi;
            r_s8_x2a   <= $signed(r_s7_ac2b6[43:11]);
            r_s8_x1b   <= $signed(r_s7_ac3b6[43:13]);
            r_s8_t     <= r_s7_t;
            r_s8_up    <= r_s7_up;
            r_s8_oss   <= r_s7_oss;

            r_s9_b2sq  <= n_b2sq;
            r_s9_b1sq  <= n_b1sq;
            r_s9_x2a   <= r_s8_x2a;
            r_s9_x1b   <= r_s8_x1b;
            r_s9_t     <= r_s8_t;
            r_s9_up    <= r_s8_up;
            r_s9_oss   <= r_s8_oss;

            r_s10_x3a  <= n_x3a;
            r_s10_x3b  <= w_x3b_sum[33:2];
            r_s10_t    <= r_s9_t;
            r_s10_up   <= r_s9_up;
            r_s10_oss  <= r_s9_oss;

            r_s11_b3   <= w_b3_sh[33:2];
            r_s11_u    <= n_u;
            r_s11_t    <= r_s10_t;
            r_s11_up   <= r_s10_up;
            r_s11_oss  <= r_s10_oss;

            r_s12_b4   <= n_b4p[47:15];
            r_s12_diff <= n_diff;
            r_s12_t    <= r_s11_t;
            r_s12_oss  <= r_s11_oss;

            r_s13_b7   <= n_b7;
            r_s13_b4   <= r_s12_b4;
            r_s13_t    <= r_s12_t;

            r_pside[0] <= w_pside_in;
            for (int k = 1; k < DIV_W; k++) begin
                r_pside[k] <= r_pside[k-1];
            end

            r_s14_p    <= n_p;
            r_s14_sat  <= |w_pq[33:19];
            r_s14_s    <= n_s;
            r_s14_m    <= n_m;
            r_s14_bz   <= w_pside_out.bz;
            r_s14_t    <= w_pside_out.temp;

            r_s15_x1   <= w_k1p[33:16];
            r_s15_x2   <= $signed(w_negm[32:16]);
            r_s15_p    <= r_s14_p;
            r_s15_sat  <= r_s14_sat;
            r_s15_bz   <= r_s14_bz;
            r_s15_t    <= r_s14_t;

            r_out_p     <= n_out_p;
            r_out_fault <= r_s15_bz;
            r_out_t     <= r_s15_t;
        end
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = {6'b0, r_out_p, r_out_t};
    assign o_m_axis_tuser  = r_out_fault;

    `PTC_ASSERT_SAME(a_fault_zero_pressure, i_clk, i_rst_n,
        o_m_axis_tvalid && o_m_axis_tuser, o_m_axis_tdata[33:16] == '0,
        "divide fault word must carry zero pressure")

    `PTC_ASSERT_SAME(a_ready_when_empty, i_clk, i_rst_n,
        !o_m_axis_tvalid, o_s_axis_tready,
        "input stalled while output register is empty")

    `PTC_ASSERT_NEXT(a_last_stage_lands, i_clk, i_rst_n,
        w_en && r_s15_vld, o_m_axis_tvalid,
        "word in final stage did not reach the output register")

endmodule

/* sv/ptc_div.sv */
// ----------------------------------------------------------------------------
// ptc_div
// Pipelined unsigned restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
`include "pressure_temp_compensation_defines.svh"

module ptc_div
    import ptc_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_en,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic [DIV_W-1:0] r_dvd [DIV_W];
    logic [DIV_W-1:0] r_rem [DIV_W];
    logic [DIV_W-1:0] r_quo [DIV_W];
    logic [DIV_W-1:0] r_dvs [DIV_W];
    logic             r_vld [DIV_W];

    for (genvar k = 0; k < DIV_W; k++) begin : g_stage
        logic [DIV_W-1:0] w_dvd;
        logic [DIV_W-1:0] w_rem;
        logic [DIV_W-1:0] w_quo;
        logic [DIV_W-1:0] w_dvs;
        logic             w_vld;
        logic [DIV_W:0]   w_trial;
        logic [DIV_W:0]   w_diff;

        if (k == 0) begin : g_first
            assign w_dvd = i_req.dividend;
            assign w_rem = '0;
            assign w_quo = '0;
            assign w_dvs = i_req.divisor;
            assign w_vld = i_req.valid;
        end else begin : g_next
            assign w_dvd = r_dvd[k-1];
            assign w_rem = r_rem[k-1];
            assign w_quo = r_quo[k-1];
            assign w_dvs = r_dvs[k-1];
            assign w_vld = r_vld[k-1];
        end

        assign w_trial = {w_rem, w_dvd[DIV_W-1]};
        assign w_diff  = w_trial - {1'b0, w_dvs};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= w_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_dvs[k] <= w_dvs;
                r_dvd[k] <= {w_dvd[DIV_W-2:0], 1'b0};
                if (w_trial >= {1'b0, w_dvs}) begin
                    r_rem[k] <= w_diff[DIV_W-1:0];
                    r_quo[k] <= {w_quo[DIV_W-2:0], 1'b1};
                end else begin
                    r_rem[k] <= w_trial[DIV_W-1:0];
                    r_quo[k] <= {w_quo[DIV_W-2:0], 1'b0};
                end
            end
        end
    end

    assign o_rsp.valid    = r_vld[DIV_W-1];
    assign o_rsp.quotient = r_quo[DIV_W-1];

    `PTC_ASSERT_SAME(a_rem_below_divisor, i_clk, i_rst_n,
        o_rsp.valid && (r_dvs[DIV_W-1] != '0), r_rem[DIV_W-1] < r_dvs[DIV_W-1],
        "divider remainder not below divisor")

    `PTC_ASSERT_SAME(a_zero_divisor_ones, i_clk, i_rst_n,
        o_rsp.valid && (r_dvs[DIV_W-1] == '0), &r_quo[DIV_W-1],
        "zero divisor must give an all-ones quotient")

endmodule

/* tb/sv/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Drives raw temperature/pressure words through the compensation block under
// several calibration sets, predicts each output word in integer arithmetic
// and compares temperature, pressure and fault flag in order.
// ----------------------------------------------------------------------------
class comp_scoreboard;
    logic [31:0] coef [5];
    logic [15:0] exp_temp [$];
    logic [17:0] exp_pres [$];
    logic        exp_fault [$];
    int          errors;

    function longint asr(longint v, int n);
        return v >>> n;
    endfunction

    function longint div_trunc(longint a, longint b);
        longint q;
        q = (a < 0 ? -a : a) / (b < 0 ? -b : b);
        return ((a < 0) != (b < 0)) ? -q : q;
    endfunction

    function void note_input(logic [15:0] ut_in, logic [18:0] up_in, logic [1:0] oss);
        longint ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
        longint ut, up, x1, x2, x3, b3, b5, b6, t, p, sq, den;
        longint unsigned b4, b7, q, u;
        ac1 = longint'($signed(coef[0][31:16])); ac2 = longint'($signed(coef[0][15:0]));
        ac3 = longint'($signed(coef[1][31:16])); ac4 = longint'(coef[1][15:0]);
        ac5 = longint'(coef[2][31:16]);          ac6 = longint'(coef[2][15:0]);
        b1  = longint'($signed(coef[3][31:16])); b2  = longint'($signed(coef[3][15:0]));
        mc  = longint'($signed(coef[4][31:16])); md  = longint'($signed(coef[4][15:0]));
        ut = longint'(ut_in); up = longint'(up_in);
        x1 = asr((ut - ac6) * ac5, 15);
        den = x1 + md;
        x2 = (den != 0) ? div_trunc(mc * 2048, den) : 0;
        b5 = x1 + x2;
        t = asr(b5 + 8, 4);
        if (t > 32767) t = 32767;
        if (t < -32768) t = -32768;
        exp_temp.push_back(t[15:0]);
        b6 = b5 - 4000;
        sq = asr(b6 * b6, 12);
        x3 = asr(b2 * sq, 11) + asr(ac2 * b6, 11);
        b3 = asr((ac1 * 4 + x3) * (longint'(1) << oss) + 2, 2);
        x1 = asr(ac3 * b6, 13);
        x2 = asr(b1 * sq, 16);
        x3 = asr(x1 + x2 + 2, 2);
        u = (x3 + 32768) & 64'hFFFF_FFFF;
        b4 = (ac4 * u) >> 15;
        b7 = ((up - b3) & 64'hFFFF_FFFF) * (50000 >> oss);
        b7 &= 64'hFFFF_FFFF;
        if (b4 == 0) begin
            exp_pres.push_back('0);
            exp_fault.push_back(1'b1);
            return;
        end
        q = (b7 < 64'h8000_0000) ? (b7 * 2) / b4 : (b7 / b4) * 2;
        p = longint'(q);
        x1 = (p >>> 8) * (p >>> 8);
        x1 = asr(x1 * 3038, 16);
        x2 = asr(-7357 * p, 16);
        p = p + asr(x1 + x2 + 3791, 4);
        if (p < 0) p = 0;
        if (p > 262143) p = 262143;
        exp_pres.push_back(p[17:0]);
        exp_fault.push_back(1'b0);
    endfunction

    function void check_output(logic [15:0] t, logic [17:0] p, logic f);
        if (exp_temp.size() == 0) begin
            $error("unexpected output word");
            errors++;
            return;
        end
        if (t !== exp_temp[0]) begin
            $error("temperature_tenths exp %0d got %0d",
                   $signed(exp_temp[0]), $signed(t));
            errors++;
        end
        if (p !== exp_pres[0]) begin
            $error("pressure_pascal exp %0d got %0d", exp_pres[0], p);
            errors++;
        end
        if (f !== exp_fault[0]) begin
            $error("divide_fault exp %0d got %0d", exp_fault[0], f);
            errors++;
        end
        void'(exp_temp.pop_front());
        void'(exp_pres.pop_front());
        void'(exp_fault.pop_front());
    endfunction
endclass

module testbench;
    import ptc_pkg::*;

    logic                   clk = 0;
    logic                   rst_n = 0;
    logic                   cfg_we = 0;
    logic [CFG_ADDR_W-1:0]  cfg_addr = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;
    logic                   s_tvalid = 0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;
    logic                   m_tvalid;
    logic                   m_tready = 0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   m_tuser;

    comp_scoreboard sb;
    bit calm = 0;
    bit long_hold = 0;

    always #5 clk = ~clk;

    pressure_temp_compensation dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_cfg_we(cfg_we), .i_cfg_addr(cfg_addr), .i_cfg_wdata(cfg_wdata),
        .i_s_axis_tvalid(s_tvalid), .o_s_axis_tready(s_tready), .i_s_axis_tdata(s_tdata),
        .o_m_axis_tvalid(m_tvalid), .i_m_axis_tready(m_tready), .o_m_axis_tdata(m_tdata),
        .o_m_axis_tuser(m_tuser)
    );

    always @(posedge clk) begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_output(m_tdata[15:0], m_tdata[33:16], m_tuser);
    end

    // receiver: random stall bursts, one long hold-off on request
    initial begin
        int n;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            if (long_hold) begin
                m_tready <= 0;
                repeat (400) @(negedge clk);
                long_hold = 0;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                n = $urandom_range(1, 13);
                m_tready <= 0;
                repeat (n - 1) @(negedge clk);
            end else begin
                m_tready <= 1;
            end
        end
    end

    task automatic write_coef(t_cfg_idx idx, logic [31:0] v);
        @(negedge clk);
        cfg_we <= 1; cfg_addr <= idx; cfg_wdata <= v;
        sb.coef[idx] = v;
        @(negedge clk);
        cfg_we <= 0;
    endtask

    task automatic drain();
        while (sb.exp_temp.size() != 0) @(negedge clk);
        repeat (100) @(negedge clk);
    endtask

    task automatic load_set(logic [31:0] a, b, c, d, e);
        drain();
        write_coef(CFG_AC1_AC2, a);
        write_coef(CFG_AC3_AC4, b);
        write_coef(CFG_AC5_AC6, c);
        write_coef(CFG_B1_B2, d);
        write_coef(CFG_MC_MD, e);
    endtask

    // called at negedge; returns after accept and leaves valid high until the next word or finish_burst
    task automatic send_word(logic [15:0] ut, logic [18:0] up, logic [1:0] oss);
        int n;
        if (!calm && $urandom_range(0, 7) == 0) begin
            n = $urandom_range(1, 13);
            s_tvalid <= 0;
            repeat (n) @(negedge clk);
        end
        s_tvalid <= 1;
        s_tdata <= {3'b0, oss, up, ut};
        do @(posedge clk); while (!s_tready);
        sb.note_input(ut, up, oss);
        @(negedge clk);
    endtask

    task automatic finish_burst();
        s_tvalid <= 0;
    endtask

    task automatic random_run(int cnt);
        for (int i = 0; i < cnt; i++)
            send_word(16'($urandom), 19'($urandom_range(0, 524287)),
                      2'($urandom_range(0, 3)));
        finish_burst();
    endtask

    initial begin
        sb = new();
        sb.errors = 0;
        for (int i = 0; i < 5; i++) sb.coef[i] = '0;
        repeat (3) @(negedge clk);
        rst_n <= 1;
        // reset coefficients: zero divisors everywhere
        @(negedge clk);
        send_word(16'h0000, 19'h0, 2'd0);
        send_word(16'hFFFF, 19'h7FFFF, 2'd3);
        finish_burst();
        // typical datasheet calibration
        load_set({16'd408, -16'sd72}, {-16'sd14383, 16'd32741}, {16'd32757, 16'd23153},
                 {16'd6190, 16'd4}, {-16'sd8711, 16'd2868});
        send_word(16'd27898, 19'd23843, 2'd0);
        for (int o = 0; o < 4; o++) send_word(16'd27898, 19'd23843 << o, o[1:0]);
        send_word(16'h0000, 19'h00000, 2'd0);
        send_word(16'hFFFF, 19'h7FFFF, 2'd3);
        send_word(16'hFFFF, 19'h00000, 2'd1);
        send_word(16'h0000, 19'h7FFFF, 2'd2);
        send_word(16'h5555, 19'h2AAAA, 2'd1);
        send_word(16'hAAAA, 19'h55555, 2'd2);
        finish_burst();
        // pause until all results arrive
        drain();
        random_run(300);
        // long receiver hold-off while input keeps offering
        drain();
        long_hold = 1;
        random_run(200);
        // zero temperature divisor: ac5=0 gives x1=0, md=0
        load_set({16'd408, -16'sd72}, {-16'sd14383, 16'd32741}, {16'd0, 16'd23153},
                 {16'd6190, 16'd4}, {-16'sd8711, 16'd0});
        send_word(16'd27898, 19'd23843, 2'd0);
        send_word(16'hFFFF, 19'h7FFFF, 2'd3);
        finish_burst();
        // extremes
        load_set(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        random_run(150);
        load_set(32'h7FFF_8000, 32'h8000_FFFF, 32'hFFFF_0000, 32'h7FFF_8000, 32'h8000_7FFF);
        random_run(150);
        load_set(32'h8000_7FFF, 32'h7FFF_0001, 32'h0001_FFFF, 32'h8000_7FFF, 32'h7FFF_8000);
        random_run(150);
        // random calibration sets
        for (int k = 0; k < 3; k++) begin
            load_set($urandom, $urandom, $urandom, $urandom, $urandom);
            random_run(100);
        end
        // last part without idling
        load_set({16'd408, -16'sd72}, {-16'sd14383, 16'd32741}, {16'd32757, 16'd23153},
                 {16'd6190, 16'd4}, {-16'sd8711, 16'd2868});
        calm = 1;
        random_run(150);
        drain();
        if (sb.errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial begin
        #2000000;
        $display("tb: failure");
        $finish;
    end
endmodule
